// ===== hw/rtl/tzbpl_pkg.sv =====
// shared types and constants of the three-zone bright pixel level block
package tzbpl_pkg;

   localparam int NUM_ZONES  = 3;
   localparam int LEVEL_W    = 7;
   localparam int RED_W      = 8;
   localparam int COLUMN_W   = 10;
   localparam int WIDTH_W    = 11;
   localparam int THIRD_W    = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int STEP_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RED_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 1'b1;

   // reset values of the registers and of the derived zone bounds
   localparam logic [RED_W-1:0]   THRESHOLD_RESET  = 8'd127;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET      = 11'd640;
   localparam logic [THIRD_W-1:0] THIRD_RESET      = 10'd213;
   localparam logic [WIDTH_W-1:0] TWO_THIRD_RESET  = 11'd426;

   // floor(w/3) as (w*2731)>>13, exact for every 11-bit w
   localparam logic [11:0] THIRD_RECIP = 12'd2731;
   localparam int          THIRD_SHIFT = 13;

   // zone indexes
   localparam logic [1:0] ZONE_LEFT   = 2'd0;
   localparam logic [1:0] ZONE_MIDDLE = 2'd1;
   localparam logic [1:0] ZONE_RIGHT  = 2'd2;

   // one quotient bit per step, seven steps per zone
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       accum;
      logic       load;
      logic       step;
      logic       last_step;
      logic       publish;
      logic [1:0] zone;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/tzbpl_ctrl.sv =====
// controller: pixel acceptance and sequencing of the per-frame divisions
module tzbpl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_frame_last,
   output logic                     req_ready,
   input  tzbpl_pkg::dp_status_type status,
   output tzbpl_pkg::ctl_cmd_type   cmd
);
   import tzbpl_pkg::*;

   state_type         state_ff, state_in;
   logic [1:0]        zone_ff, zone_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         zone_ff  <= ZONE_LEFT;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         zone_ff  <= zone_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      zone_in   = zone_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.zone  = zone_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accum = req_valid;
            if (req_valid && req_frame_last) begin
               state_in = ST_LOAD;
               zone_in  = ZONE_LEFT;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (step_ff == LAST_STEP) begin
               cmd.last_step = 1'b1;
               if (zone_ff == ZONE_RIGHT) begin
                  state_in = ST_FINISH;
               end else begin
                  zone_in  = zone_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/tzbpl_dpath.sv =====
// datapath: config registers, zone accumulators, shift-subtract divider, output register
module tzbpl_dpath #(
   parameter int MAX_FRAME_PIXELS = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tzbpl_pkg::ctl_cmd_type              cmd,
   output tzbpl_pkg::dp_status_type            status,
   input  logic                                csr_we,
   input  logic [tzbpl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tzbpl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [tzbpl_pkg::RED_W-1:0]         req_pixel_red,
   input  logic [tzbpl_pkg::COLUMN_W-1:0]      req_pixel_column,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [tzbpl_pkg::LEVEL_W-1:0]       rsp_level_left,
   output logic [tzbpl_pkg::LEVEL_W-1:0]       rsp_level_middle,
   output logic [tzbpl_pkg::LEVEL_W-1:0]       rsp_level_right
);
   import tzbpl_pkg::*;

   localparam int SUM_W = $clog2(255 * MAX_FRAME_PIXELS + 1);
   localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 2);
   localparam int DIV_W = (SUM_W + 7 > CNT_W + 14) ? SUM_W + 7 : CNT_W + 14;
   localparam logic [SUM_W:0]   SUM_CAP   = (SUM_W+1)'(255 * MAX_FRAME_PIXELS);
   localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_FRAME_PIXELS + 1);
   localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

   // configuration and derived zone bounds
   logic [RED_W-1:0]   threshold_ff, threshold_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [THIRD_W-1:0] third_ff, third_in;
   logic [WIDTH_W-1:0] two_third_ff, two_third_in;
   logic [23:0]        third_prod;

   // accumulators
   logic [SUM_W-1:0] sum_ff [NUM_ZONES];
   logic [SUM_W-1:0] sum_in [NUM_ZONES];
   logic [CNT_W-1:0] cnt_ff [NUM_ZONES];
   logic [CNT_W-1:0] cnt_in [NUM_ZONES];
   logic [NUM_ZONES-1:0] hit;
   logic [WIDTH_W-1:0]   col;
   logic                 bright;

   // divider
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [LEVEL_W-1:0] q_ff, q_in;
   logic [DIV_W:0]     diff;
   logic               take;
   logic [LEVEL_W-1:0] q_step;
   logic [SUM_W-1:0]   sel_sum;
   logic [CNT_W-1:0]   sel_cnt;
   logic [DIV_W-1:0]   sum_ext, cnt_ext;

   logic [LEVEL_W-1:0] level_ff [NUM_ZONES];
   logic [LEVEL_W-1:0] level_in [NUM_ZONES];

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] out_left_ff, out_left_in;
   logic [LEVEL_W-1:0] out_middle_ff, out_middle_in;
   logic [LEVEL_W-1:0] out_right_ff, out_right_in;

   // config writes
   always_comb begin
      threshold_in = threshold_ff;
      width_in     = width_ff;
      third_in     = third_ff;
      two_third_in = two_third_ff;
      third_prod   = 24'(csr_wdata) * 24'(THIRD_RECIP);
      if (csr_we) begin
         case (csr_index)
            CSR_RED_THRESHOLD: threshold_in = csr_wdata[RED_W-1:0];
            CSR_IMAGE_WIDTH: begin
               width_in     = csr_wdata[WIDTH_W-1:0];
               third_in     = third_prod[THIRD_SHIFT +: THIRD_W];
               two_third_in = {third_prod[THIRD_SHIFT +: THIRD_W], 1'b0};
            end
            default: ;
         endcase
      end
   end

   // zone membership of the incoming pixel
   always_comb begin
      col    = WIDTH_W'(req_pixel_column);
      bright = req_pixel_red > threshold_ff;
      hit[0] = bright && (col < WIDTH_W'(third_ff));
      hit[1] = bright && (col > WIDTH_W'(third_ff)) && (col < two_third_ff);
      hit[2] = bright && (col > two_third_ff) && (col < width_ff);
   end

   // saturating accumulation, cleared when a result is published
   always_comb begin
      logic [SUM_W:0] s;
      for (int z = 0; z < NUM_ZONES; z++) begin
         s         = {1'b0, sum_ff[z]} + (SUM_W+1)'(req_pixel_red);
         sum_in[z] = sum_ff[z];
         cnt_in[z] = cnt_ff[z];
         if (cmd.publish) begin
            sum_in[z] = '0;
            cnt_in[z] = COUNT_ONE;
         end else if (cmd.accum && hit[z]) begin
            sum_in[z] = (s > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s[SUM_W-1:0];
            if (cnt_ff[z] < COUNT_CAP) begin
               cnt_in[z] = cnt_ff[z] + COUNT_ONE;
            end
         end
      end
   end

   // sum*127 / (count*255), restoring division with a 7-bit quotient
   always_comb begin
      sel_sum = sum_ff[cmd.zone];
      sel_cnt = cnt_ff[cmd.zone];
      sum_ext = DIV_W'(sel_sum);
      cnt_ext = DIV_W'(sel_cnt);
      diff    = {1'b0, rem_ff} - {1'b0, div_ff};
      take    = !diff[DIV_W];
      q_step  = {q_ff[LEVEL_W-2:0], take};
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      for (int z = 0; z < NUM_ZONES; z++) begin
         level_in[z] = level_ff[z];
      end
      if (cmd.load) begin
         rem_in = (sum_ext << 7) - sum_ext;
         div_in = ((cnt_ext << 8) - cnt_ext) << (LEVEL_W - 1);
         q_in   = '0;
      end else if (cmd.step) begin
         if (take) begin
            rem_in = diff[DIV_W-1:0];
         end
         div_in = div_ff >> 1;
         q_in   = q_step;
         if (cmd.last_step) begin
            level_in[cmd.zone] = q_step;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_left_in   = out_left_ff;
      out_middle_in = out_middle_ff;
      out_right_in  = out_right_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in  = 1'b1;
         out_left_in   = level_ff[ZONE_LEFT];
         out_middle_in = level_ff[ZONE_MIDDLE];
         out_right_in  = level_ff[ZONE_RIGHT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         third_ff     <= THIRD_RESET;
         two_third_ff <= TWO_THIRD_RESET;
         rsp_valid_ff <= 1'b0;
         for (int z = 0; z < NUM_ZONES; z++) begin
            sum_ff[z] <= '0;
            cnt_ff[z] <= COUNT_ONE;
         end
      end else begin
         threshold_ff <= threshold_in;
         width_ff     <= width_in;
         third_ff     <= third_in;
         two_third_ff <= two_third_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int z = 0; z < NUM_ZONES; z++) begin
            sum_ff[z] <= sum_in[z];
            cnt_ff[z] <= cnt_in[z];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      q_ff          <= q_in;
      out_left_ff   <= out_left_in;
      out_middle_ff <= out_middle_in;
      out_right_ff  <= out_right_in;
      for (int z = 0; z < NUM_ZONES; z++) begin
         level_ff[z] <= level_in[z];
      end
   end

   assign status.out_free  = !rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level_left   = out_left_ff;
   assign rsp_level_middle = out_middle_ff;
   assign rsp_level_right  = out_right_ff;

endmodule

// ===== hw/rtl/three_zone_bright_pixel_level_top.sv =====
// top level of the three-zone bright pixel level block
// Takes a frame of pixels, one per transfer, and splits the width into a left, middle and
// right zone at floor(w/3) and 2*floor(w/3); pixels on those two boundary columns, and at or
// beyond the width, belong to no zone. Per zone it sums red values strictly above the
// threshold and counts those pixels (count starts at 1, both saturate). The transfer that
// carries frame_last closes the frame and yields one result of three levels
// floor(sum*127/(count*255)), 0 to 127, after which the zones restart empty. Pixels are
// taken at one per cycle. After the last pixel of a frame the input stalls while one
// shared shift-subtract divider works through the zones (a load, then the quotient bits one
// by one, per zone) and the result moves into the output register; if the previous result
// is still untaken, the stall lasts until it is. While a result waits in the output register
// the next frame's pixels are accepted. Write the registers only while the block is idle.
module three_zone_bright_pixel_level_top #(
   parameter int MAX_FRAME_PIXELS = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_we,
   input  logic [tzbpl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tzbpl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tzbpl_pkg::RED_W-1:0]         req_pixel_red,
   input  logic [tzbpl_pkg::COLUMN_W-1:0]      req_pixel_column,
   input  logic                                req_frame_last,
   // level result
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tzbpl_pkg::LEVEL_W-1:0]       rsp_level_left,
   output logic [tzbpl_pkg::LEVEL_W-1:0]       rsp_level_middle,
   output logic [tzbpl_pkg::LEVEL_W-1:0]       rsp_level_right
);
   import tzbpl_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   // sequencing: pixel accept, per-zone load/step, publish
   tzbpl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_frame_last (req_frame_last),
      .req_ready      (req_ready),
      .status         (dp_status),
      .cmd            (ctl_cmd)
   );

   // accumulators, divider and output register
   tzbpl_dpath #(
      .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctl_cmd),
      .status           (dp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_pixel_red    (req_pixel_red),
      .req_pixel_column (req_pixel_column),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_level_left   (rsp_level_left),
      .rsp_level_middle (rsp_level_middle),
      .rsp_level_right  (rsp_level_right)
   );

`ifndef NO_ASSERTIONS
   // a result only appears as the outcome of a publish
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl_cmd.publish))
      else $error("result valid without publish");

   // no pixel is taken while the divider is busy
   assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.load || ctl_cmd.step || ctl_cmd.publish) |-> !req_ready)
      else $error("pixel accepted during division");

   // closing a frame starts division with the left zone
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_frame_last) |=>
         (ctl_cmd.load && ctl_cmd.zone == ZONE_LEFT))
      else $error("frame end did not start division");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for the three-zone bright pixel level block: directed and random frames
module tb_top;
   import tzbpl_pkg::*;

   // frame cap of the block, the full size so that results follow the nominal behavior
   localparam int PIXEL_CAP     = 1048576;
   localparam int SUM_W         = 28;
   localparam int HITS_W        = 21;
   // far beyond the divider's work on a frame, so longer than any correct stall
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PIXELS = 1850;
   localparam int MAX_REPORTS   = 40;

   // one level result, one field per zone
   typedef struct packed {
      logic [LEVEL_W-1:0] left;
      logic [LEVEL_W-1:0] middle;
      logic [LEVEL_W-1:0] right;
   } levels_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic [RED_W-1:0]      req_pixel_red;
   logic [COLUMN_W-1:0]   req_pixel_column;
   logic                  req_frame_last;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [LEVEL_W-1:0]    rsp_level_left;
   logic [LEVEL_W-1:0]    rsp_level_middle;
   logic [LEVEL_W-1:0]    rsp_level_right;

   three_zone_bright_pixel_level_top #(
      .MAX_FRAME_PIXELS(PIXEL_CAP)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_column(req_pixel_column),
      .req_frame_last  (req_frame_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_level_left  (rsp_level_left),
      .rsp_level_middle(rsp_level_middle),
      .rsp_level_right (rsp_level_right)
   );

   // shadow of the registers and the per-zone accumulators
   logic [RED_W-1:0]   shadow_threshold;
   logic [WIDTH_W-1:0] shadow_width;
   logic [SUM_W-1:0]   zone_sum  [NUM_ZONES];
   logic [HITS_W-1:0]  zone_hits [NUM_ZONES];

   // levels still owed by the block, oldest first
   levels_type pending_levels[$];

   int error_count;
   int frames_sent;
   int pixels_sent;
   int csr_writes;
   int levels_checked;
   int idle_cycles;
   // when set, neither side inserts idle cycles
   bit steady;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // predictor
   // -------------------------------------------------------------------------

   // zones restart empty: sum 0, count 1
   function automatic void clear_zones();
      for (int z = 0; z < NUM_ZONES; z++) begin
         zone_sum[z]  = '0;
         zone_hits[z] = HITS_W'(1);
      end
   endfunction

   // add one bright pixel to a zone, both accumulators saturate
   function automatic void add_bright(int z, logic [RED_W-1:0] red);
      longint s;
      s = longint'(zone_sum[z]) + longint'(red);
      if (s > longint'(255) * PIXEL_CAP)
         s = longint'(255) * PIXEL_CAP;
      zone_sum[z] = s[SUM_W-1:0];
      if (zone_hits[z] < PIXEL_CAP + 1)
         zone_hits[z] = zone_hits[z] + 1'b1;
   endfunction

   // floor(sum*127/(count*255)), held at 127
   function automatic logic [LEVEL_W-1:0] zone_level(int z);
      longint lvl;
      longint cnt;
      cnt = longint'(zone_hits[z]);
      if (cnt == 0)
         cnt = 1;
      lvl = (longint'(zone_sum[z]) * 127) / (cnt * 255);
      if (lvl > 127)
         lvl = 127;
      return lvl[LEVEL_W-1:0];
   endfunction

   // take in one accepted pixel; the frame's last pixel owes one result
   function automatic void accumulate_pixel(logic [RED_W-1:0] red,
                                            logic [COLUMN_W-1:0] column, bit last);
      int w;
      int third;
      int two_thirds;
      int x;
      levels_type lv;
      w          = shadow_width;
      third      = w / 3;
      two_thirds = third * 2;
      x          = column;
      if (red > shadow_threshold) begin
         if (x < third)
            add_bright(ZONE_LEFT, red);
         if (x > third && x < two_thirds)
            add_bright(ZONE_MIDDLE, red);
         if (x > two_thirds && x < w)
            add_bright(ZONE_RIGHT, red);
      end
      if (last) begin
         lv.left   = zone_level(ZONE_LEFT);
         lv.middle = zone_level(ZONE_MIDDLE);
         lv.right  = zone_level(ZONE_RIGHT);
         pending_levels = {pending_levels, lv};
         clear_zones();
      end
   endfunction

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("tb_top: error: %s", msg);
   endtask

   // one pixel transfer after a random gap; valid stays high if the next pixel follows at once
   task automatic send_pixel(int red, int column, bit last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_pixel_red    <= red[RED_W-1:0];
      req_pixel_column <= column[COLUMN_W-1:0];
      req_frame_last   <= last;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      accumulate_pixel(red[RED_W-1:0], column[COLUMN_W-1:0], last);
      pixels_sent++;
      if (last)
         frames_sent++;
   endtask

   // register write, only once the block has drained its last frame
   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_levels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_RED_THRESHOLD)
         shadow_threshold = data[RED_W-1:0];
      else
         shadow_width = data[WIDTH_W-1:0];
      csr_writes++;
      // give the zone bounds a moment to follow the new width
      repeat (2) @(negedge clock);
   endtask

   // result side: random stall before each result, then ready until the transfer
   initial begin : drain_levels
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (!(rsp_valid === 1'b1 && reset === 1'b0));
      end
   end

   // -------------------------------------------------------------------------
   // checker and watchdog
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : check_levels
      levels_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_levels.size() == 0) begin
            report_error($sformatf("result %0d/%0d/%0d with no frame closed",
                                   rsp_level_left, rsp_level_middle, rsp_level_right));
         end else begin
            want = pending_levels.pop_front();
            levels_checked++;
            if (rsp_level_left !== want.left)
               report_error($sformatf("frame %0d left level %0d, expected %0d",
                                      levels_checked, rsp_level_left, want.left));
            if (rsp_level_middle !== want.middle)
               report_error($sformatf("frame %0d middle level %0d, expected %0d",
                                      levels_checked, rsp_level_middle, want.middle));
            if (rsp_level_right !== want.right)
               report_error($sformatf("frame %0d right level %0d, expected %0d",
                                      levels_checked, rsp_level_right, want.right));
         end
      end
   end

   // ends the run when neither channel has moved a transfer for too long
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: no transfer for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_levels.size());
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------

   // reset width 640: bounds at 213 and 426, threshold 127
   task automatic test_default_zones();
      send_pixel(255, 0, 1'b0);
      send_pixel(128, 212, 1'b0);
      send_pixel(200, 213, 1'b0);   // left/middle boundary
      send_pixel(127, 100, 1'b0);   // equal to threshold, not bright
      send_pixel(255, 214, 1'b0);
      send_pixel(180, 425, 1'b0);
      send_pixel(255, 426, 1'b0);   // middle/right boundary
      send_pixel(255, 427, 1'b0);
      send_pixel(255, 639, 1'b0);
      send_pixel(255, 640, 1'b0);   // at the width
      send_pixel(255, 1023, 1'b1);  // beyond the width
   endtask

   // single-pixel frames, empty zones read as level 0
   task automatic test_empty_frames();
      send_pixel(0, 0, 1'b1);
      send_pixel(255, 0, 1'b1);
   endtask

   // threshold 0 and 255, upper data bits set to check that they are dropped
   task automatic test_threshold_extremes();
      write_csr(CSR_RED_THRESHOLD, {3'b111, 8'd0});
      send_pixel(1, 5, 1'b0);
      send_pixel(0, 300, 1'b1);
      write_csr(CSR_RED_THRESHOLD, {3'b000, 8'd255});
      send_pixel(255, 5, 1'b0);
      send_pixel(255, 300, 1'b1);
      write_csr(CSR_RED_THRESHOLD, {3'b101, 8'd127});
   endtask

   // widths outside the nominal range and at its ends
   task automatic test_width_extremes();
      write_csr(CSR_IMAGE_WIDTH, 11'd0);
      send_pixel(255, 0, 1'b1);
      write_csr(CSR_IMAGE_WIDTH, 11'd2);
      send_pixel(255, 0, 1'b0);
      send_pixel(255, 1, 1'b1);
      write_csr(CSR_IMAGE_WIDTH, 11'd3);
      send_pixel(255, 0, 1'b0);
      send_pixel(255, 1, 1'b0);
      send_pixel(255, 2, 1'b1);
      write_csr(CSR_IMAGE_WIDTH, 11'd2047);
      send_pixel(255, 1023, 1'b1);
      write_csr(CSR_IMAGE_WIDTH, 11'd1024);
      send_pixel(255, 341, 1'b0);
      send_pixel(255, 682, 1'b0);
      send_pixel(200, 1023, 1'b1);
   endtask

   // columns weighted toward the zone bounds and the visible width
   function automatic int pick_column(int w);
      int third;
      int c;
      int near_bound[8];
      third = w / 3;
      near_bound = '{third - 1, third, third + 1, 2 * third - 1, 2 * third,
                     2 * third + 1, w - 1, w};
      case ($urandom_range(0, 9))
         0, 1:    c = near_bound[$urandom_range(0, 7)];
         2:       c = $urandom_range(0, 1023);
         default: c = (w > 0) ? $urandom_range(0, ((w > 1024) ? 1024 : w) - 1)
                              : $urandom_range(0, 3);
      endcase
      if (c < 0)
         c = 0;
      if (c > 1023)
         c = 1023;
      return c;
   endfunction

   // red values weighted toward the threshold and the extremes
   function automatic int pick_red();
      int thr;
      thr = shadow_threshold;
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 255;
         2:       return thr;
         3:       return (thr < 255) ? thr + 1 : 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic int pick_width();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 2);
         1:       return $urandom_range(1025, 2047);
         2:       return ($urandom_range(0, 1) != 0) ? 3 : 1024;
         3, 4:    return $urandom_range(3, 40);
         default: return $urandom_range(3, 1024);
      endcase
   endfunction

   function automatic int pick_threshold();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // random frames, now and then a long one of mostly full-scale pixels
   task automatic test_random_frames(int budget);
      int start;
      int frame_len;
      bit overlong;
      logic [2:0] pad;
      start = pixels_sent;
      write_csr(CSR_IMAGE_WIDTH, WIDTH_W'(pick_width()));
      write_csr(CSR_RED_THRESHOLD, CSR_DATA_W'(pick_threshold()));
      while (pixels_sent - start < budget) begin
         if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) != 0) begin
               write_csr(CSR_IMAGE_WIDTH, WIDTH_W'(pick_width()));
            end else begin
               pad = $urandom_range(0, 7);
               write_csr(CSR_RED_THRESHOLD, {pad, 8'(pick_threshold())});
            end
         end
         steady   = ($urandom_range(0, 3) == 0);
         overlong = ($urandom_range(0, 39) == 0);
         frame_len = overlong ? $urandom_range(150, 300)
                              : $urandom_range(1, 24);
         for (int i = 0; i < frame_len; i++) begin
            if (overlong)
               send_pixel(($urandom_range(0, 7) == 0) ? pick_red() : 255,
                          pick_column(shadow_width), i == frame_len - 1);
            else
               send_pixel(pick_red(), pick_column(shadow_width), i == frame_len - 1);
         end
      end
      steady = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_pixel_red    = '0;
      req_pixel_column = '0;
      req_frame_last   = 1'b0;
      steady           = 1'b0;
      error_count      = 0;
      frames_sent      = 0;
      pixels_sent      = 0;
      csr_writes       = 0;
      levels_checked   = 0;
      idle_cycles      = 0;
      shadow_threshold = THRESHOLD_RESET;
      shadow_width     = WIDTH_RESET;
      clear_zones();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_zones();
      test_empty_frames();
      test_threshold_extremes();
      test_width_extremes();
      test_random_frames(RANDOM_PIXELS);

      // drain the last results, then watch for strays
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_levels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("tb_top: %0d pixels in %0d frames, %0d register writes, %0d results checked",
               pixels_sent, frames_sent, csr_writes, levels_checked);
      $display("tb_top: widths 0 to 2047, thresholds 0 to 255, long bright frames included");
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
